// ===== src/csc_pkg.sv =====
// Shared constants, types and command codes for the crop, scale and circle mask core.
package csc_pkg;

   // Geometry and storage
   localparam int DISPLAY_SIZE = 480;
   localparam int STORE_DEPTH  = 262144;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   // Field widths
   localparam int COLOR_W = 16;
   localparam int DISP_W  = 9;
   localparam int SRC_W   = 10;
   localparam int CFG_W   = 11;
   localparam int RAD_W   = 9;
   localparam int CSR_IDX_W = 3;

   // Datapath widths
   localparam int IDX_W  = CFG_W;            // crop row / column index
   localparam int POS_W  = CFG_W + 1;        // signed source offset
   localparam int PROD_W = DISP_W + CFG_W;   // display index times crop size
   localparam int LIN_W  = 2 * IDX_W;        // row * pitch + column
   localparam int HALF   = DISPLAY_SIZE / 2;
   localparam int DD_W   = DISP_W + 2;       // signed distance from display center
   localparam int SUM_W  = 2 * DD_W - 1;     // squared distances and radius

   // Divide by DISPLAY_SIZE through a reciprocal and one correction step
   localparam int RECIP_SHIFT = PROD_W;
   localparam int RECIP       = (1 << RECIP_SHIFT) / DISPLAY_SIZE;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int T_W         = PROD_W + RECIP_W;
   localparam int Q_W         = PROD_W - $clog2(DISPLAY_SIZE) + 1;

   // Queues
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_W      = $clog2(OUT_DEPTH);

   // Request commands
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_RENDER = 2'd1,
      CMD_CLEAR  = 2'd2
   } csc_cmd_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CROP_LEFT   = 3'd0,
      CSR_CROP_TOP    = 3'd1,
      CSR_CROP_WIDTH  = 3'd2,
      CSR_CROP_HEIGHT = 3'd3,
      CSR_IMAGE_WIDTH = 3'd4,
      CSR_DATA_RIGHT  = 3'd5,
      CSR_DATA_TOP    = 3'd6,
      CSR_MASK_RADIUS = 3'd7
   } csc_csr_type;

   // Configuration registers
   typedef struct packed {
      logic signed [CFG_W-1:0] crop_left;
      logic signed [CFG_W-1:0] crop_top;
      logic        [CFG_W-1:0] crop_width;
      logic        [CFG_W-1:0] crop_height;
      logic        [CFG_W-1:0] image_width;
      logic        [SRC_W-1:0] data_right;
      logic signed [CFG_W-1:0] data_top;
      logic        [RAD_W-1:0] mask_radius;
   } csc_cfg_type;

   // Classified request from the front end to the back end
   typedef struct packed {
      csc_cmd_type         op;
      logic                hit;      // store access takes place
      logic [ADDR_W-1:0]   addr;
      logic [COLOR_W-1:0]  wdata;
      logic [DISP_W-1:0]   out_x;
      logic [DISP_W-1:0]   out_y;
      logic                in_mask;
   } csc_req_type;

endpackage

// ===== src/csc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/csc_front.sv =====
// Front end: classifies requests, maps display pixels to crop addresses, evaluates the mask.
module csc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  csc_pkg::csc_cfg_type         cfg,
   input  logic                         in_valid,
   input  logic [1:0]                   in_command,
   input  logic [csc_pkg::SRC_W-1:0]    in_src_x,
   input  logic [csc_pkg::SRC_W-1:0]    in_src_y,
   input  logic [csc_pkg::COLOR_W-1:0]  in_src_color,
   input  logic [csc_pkg::DISP_W-1:0]   in_disp_x,
   input  logic [csc_pkg::DISP_W-1:0]   in_disp_y,
   output logic                         stall,
   input  logic                         q_full,
   output logic                         q_push,
   output csc_pkg::csc_req_type         q_data
);
   import csc_pkg::*;

   // Fields every stage carries along
   typedef struct packed {
      logic               valid;
      logic               keep;
      csc_cmd_type        op;
      logic [COLOR_W-1:0] wd;
      logic [DISP_W-1:0]  dx;
      logic [DISP_W-1:0]  dy;
   } carry_type;

   carry_type c1_in, c1_ff, c2_in, c2_ff, c3_in, c3_ff;
   carry_type c4_in, c4_ff, c5_in, c5_ff, c6_in, c6_ff;

   logic adv;

   // Stage 1: source offsets, window test, display distances, index products
   logic signed [POS_W-1:0]  row, col;
   logic                     win, have;
   logic [IDX_W-1:0]         ly1_in, ly1_ff, lx1_in, lx1_ff;
   logic signed [DD_W-1:0]   ddx1_in, ddx1_ff, ddy1_in, ddy1_ff;
   logic [PROD_W-1:0]        py1_in, py1_ff, px1_in, px1_ff;

   always_comb begin
      row = $signed(POS_W'(in_src_y)) - $signed({cfg.crop_top[CFG_W-1], cfg.crop_top});
      col = $signed(POS_W'(in_src_x)) - $signed({cfg.crop_left[CFG_W-1], cfg.crop_left});
      win = !row[POS_W-1] && (row[CFG_W-1:0] < cfg.crop_height) &&
            !col[POS_W-1] && (col[CFG_W-1:0] < cfg.crop_width);
      have = (CFG_W'(in_src_x) < cfg.image_width) && (in_src_x <= cfg.data_right) &&
             ($signed(POS_W'(in_src_y)) >= $signed({cfg.data_top[CFG_W-1], cfg.data_top}));

      c1_in.valid = in_valid;
      c1_in.op    = csc_cmd_type'(in_command);
      c1_in.wd    = have ? in_src_color : '0;
      c1_in.dx    = in_disp_x;
      c1_in.dy    = in_disp_y;
      case (csc_cmd_type'(in_command))
         CMD_LOAD:   c1_in.keep = win;
         CMD_RENDER: c1_in.keep = 1'b1;
         CMD_CLEAR:  c1_in.keep = 1'b1;
         default:    c1_in.keep = 1'b0;
      endcase

      ly1_in  = row[IDX_W-1:0];
      lx1_in  = col[IDX_W-1:0];
      ddx1_in = $signed(DD_W'(in_disp_x)) - $signed(DD_W'(HALF));
      ddy1_in = $signed(DD_W'(in_disp_y)) - $signed(DD_W'(HALF));
      py1_in  = PROD_W'(in_disp_y) * PROD_W'(cfg.crop_height);
      px1_in  = PROD_W'(in_disp_x) * PROD_W'(cfg.crop_width);
   end

   // Stage 2: reciprocal products and squared distances
   logic signed [SUM_W-1:0] ex_x, ex_y;
   logic [IDX_W-1:0]        ly2_in, ly2_ff, lx2_in, lx2_ff;
   logic [PROD_W-1:0]       py2_in, py2_ff, px2_in, px2_ff;
   logic [T_W-1:0]          ty2_in, ty2_ff, tx2_in, tx2_ff;
   logic [SUM_W-1:0]        sqx2_in, sqx2_ff, sqy2_in, sqy2_ff, rr2_in, rr2_ff;

   always_comb begin
      c2_in   = c1_ff;
      ly2_in  = ly1_ff;
      lx2_in  = lx1_ff;
      py2_in  = py1_ff;
      px2_in  = px1_ff;
      ty2_in  = T_W'(py1_ff) * T_W'(RECIP);
      tx2_in  = T_W'(px1_ff) * T_W'(RECIP);
      ex_x    = SUM_W'(ddx1_ff);
      ex_y    = SUM_W'(ddy1_ff);
      sqx2_in = ex_x * ex_x;
      sqy2_in = ex_y * ex_y;
      rr2_in  = SUM_W'(cfg.mask_radius) * SUM_W'(cfg.mask_radius);
   end

   // Stage 3: quotient estimate and remainder, mask compare
   logic [Q_W-1:0]    qy0, qx0;
   logic [IDX_W-1:0]  ly3_in, ly3_ff, lx3_in, lx3_ff;
   logic [Q_W-1:0]    qy3_in, qy3_ff, qx3_in, qx3_ff;
   logic [PROD_W-1:0] remy3_in, remy3_ff, remx3_in, remx3_ff;
   logic              inside3_in, inside3_ff;

   always_comb begin
      c3_in      = c2_ff;
      ly3_in     = ly2_ff;
      lx3_in     = lx2_ff;
      qy0        = Q_W'(ty2_ff >> RECIP_SHIFT);
      qx0        = Q_W'(tx2_ff >> RECIP_SHIFT);
      qy3_in     = qy0;
      qx3_in     = qx0;
      remy3_in   = py2_ff - PROD_W'(qy0 * DISPLAY_SIZE);
      remx3_in   = px2_ff - PROD_W'(qx0 * DISPLAY_SIZE);
      inside3_in = (sqx2_ff + sqy2_ff) <= rr2_ff;
   end

   // Stage 4: quotient correction and clamp to the last crop row / column
   logic [Q_W-1:0]   qy, qx;
   logic [IDX_W-1:0] my, mx;
   logic [IDX_W-1:0] y4_in, y4_ff, x4_in, x4_ff;
   logic             inside4_in, inside4_ff;

   always_comb begin
      c4_in = c3_ff;
      qy = qy3_ff + Q_W'(remy3_ff >= PROD_W'(DISPLAY_SIZE));
      qx = qx3_ff + Q_W'(remx3_ff >= PROD_W'(DISPLAY_SIZE));
      my = (int'(qy) >= int'(cfg.crop_height)) ? IDX_W'(cfg.crop_height - 1'b1)
                                               : IDX_W'(qy);
      mx = (int'(qx) >= int'(cfg.crop_width)) ? IDX_W'(cfg.crop_width - 1'b1)
                                              : IDX_W'(qx);
      y4_in = (c3_ff.op == CMD_LOAD) ? ly3_ff : my;
      x4_in = (c3_ff.op == CMD_LOAD) ? lx3_ff : mx;
      inside4_in = inside3_ff;
   end

   // Stage 5: row times pitch
   logic [LIN_W-1:0] prod5_in, prod5_ff;
   logic [IDX_W-1:0] x5_in, x5_ff;
   logic             inside5_in, inside5_ff;

   always_comb begin
      c5_in      = c4_ff;
      prod5_in   = LIN_W'(y4_ff) * LIN_W'(cfg.crop_width);
      x5_in      = x4_ff;
      inside5_in = inside4_ff;
   end

   // Stage 6: linear address, depth check, final classification
   logic [LIN_W-1:0]  lin;
   logic              inr, nonempty;
   logic [ADDR_W-1:0] addr6_in, addr6_ff;
   logic              hit6_in, hit6_ff, inside6_in, inside6_ff;

   always_comb begin
      lin      = prod5_ff + LIN_W'(x5_ff);
      inr      = int'(lin) < STORE_DEPTH;
      nonempty = (cfg.crop_width != '0) && (cfg.crop_height != '0);
      c6_in      = c5_ff;
      c6_in.keep = c5_ff.keep && ((c5_ff.op != CMD_LOAD) || inr);
      addr6_in   = lin[ADDR_W-1:0];
      hit6_in    = (c5_ff.op == CMD_RENDER) ? (inside5_ff && nonempty && inr) : 1'b1;
      inside6_in = inside5_ff;
   end

   // Pipeline control: the whole pipe holds while the last stage waits on the queue
   assign stall  = c6_ff.valid && c6_ff.keep && q_full;
   assign adv    = !stall;
   assign q_push = c6_ff.valid && c6_ff.keep && !q_full;

   always_comb begin
      q_data.op      = c6_ff.op;
      q_data.hit     = hit6_ff;
      q_data.addr    = addr6_ff;
      q_data.wdata   = c6_ff.wd;
      q_data.out_x   = c6_ff.dx;
      q_data.out_y   = c6_ff.dy;
      q_data.in_mask = inside6_ff;
   end

   // Stage registers with valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
         c5_ff.valid <= 1'b0;
         c6_ff.valid <= 1'b0;
      end else if (adv) begin
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         c3_ff <= c3_in;
         c4_ff <= c4_in;
         c5_ff <= c5_in;
         c6_ff <= c6_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         ly1_ff     <= ly1_in;
         lx1_ff     <= lx1_in;
         ddx1_ff    <= ddx1_in;
         ddy1_ff    <= ddy1_in;
         py1_ff     <= py1_in;
         px1_ff     <= px1_in;
         ly2_ff     <= ly2_in;
         lx2_ff     <= lx2_in;
         py2_ff     <= py2_in;
         px2_ff     <= px2_in;
         ty2_ff     <= ty2_in;
         tx2_ff     <= tx2_in;
         sqx2_ff    <= sqx2_in;
         sqy2_ff    <= sqy2_in;
         rr2_ff     <= rr2_in;
         ly3_ff     <= ly3_in;
         lx3_ff     <= lx3_in;
         qy3_ff     <= qy3_in;
         qx3_ff     <= qx3_in;
         remy3_ff   <= remy3_in;
         remx3_ff   <= remx3_in;
         inside3_ff <= inside3_in;
         y4_ff      <= y4_in;
         x4_ff      <= x4_in;
         inside4_ff <= inside4_in;
         prod5_ff   <= prod5_in;
         x5_ff      <= x5_in;
         inside5_ff <= inside5_in;
         addr6_ff   <= addr6_in;
         hit6_ff    <= hit6_in;
         inside6_ff <= inside6_in;
      end
   end

endmodule

// ===== src/csc_queue.sv =====
// Short request queue between the front end and the back end.
module csc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csc_pkg::csc_req_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output csc_pkg::csc_req_type head
);
   import csc_pkg::*;

   csc_req_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [QPTR_W:0]   count_in, count_ff;
   logic              do_push, do_pop;

   assign full    = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/csc_back.sv =====
// Back end: crop store access, clearing sweep and result queue.
module csc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  csc_pkg::csc_req_type         q_head,
   output logic                         q_pop,
   output logic                         init_busy,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output logic [csc_pkg::DISP_W-1:0]   rsp_out_x,
   output logic [csc_pkg::DISP_W-1:0]   rsp_out_y,
   output logic                         rsp_inside_mask,
   output logic [csc_pkg::COLOR_W-1:0]  rsp_pixel
);
   import csc_pkg::*;

   typedef enum logic {
      ST_RUN,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [DISP_W-1:0] x;
      logic [DISP_W-1:0] y;
      logic              in_mask;
      logic              hit;
   } meta_type;

   typedef struct packed {
      logic [DISP_W-1:0]  x;
      logic [DISP_W-1:0]  y;
      logic               in_mask;
      logic [COLOR_W-1:0] pixel;
   } out_type;

   state_type         state_in, state_ff;
   logic [ADDR_W-1:0] clr_cnt_in, clr_cnt_ff;
   logic              init_in, init_ff;

   logic               wr_en, rd_en, issue;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COLOR_W-1:0] wr_data, rd_data;
   logic               space_ok;

   logic              pv_in, pv_ff;
   meta_type          pm_in, pm_ff;

   out_type           ofifo_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] owr_in, owr_ff, ord_in, ord_ff;
   logic [OPTR_W:0]   ocnt_in, ocnt_ff;
   logic              opush, opop;

   // Room in the result queue, counting a read still in flight
   assign space_ok = (int'(ocnt_ff) + int'(pv_ff)) < OUT_DEPTH;

   // Request dispatch and clearing sweep
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      init_in    = init_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = q_head.addr;
      wr_data    = q_head.wdata;
      rd_en      = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (!q_empty) begin
               case (q_head.op)
                  CMD_LOAD: begin
                     q_pop = 1'b1;
                     wr_en = 1'b1;
                  end
                  CMD_RENDER: begin
                     if (space_ok) begin
                        q_pop = 1'b1;
                        issue = 1'b1;
                        rd_en = q_head.hit;
                     end
                  end
                  CMD_CLEAR: begin
                     q_pop    = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
            if (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               clr_cnt_in = '0;
               init_in    = 1'b0;
               state_in   = ST_RUN;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Sequencer state; reset starts a full clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         init_ff    <= 1'b1;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         init_ff    <= init_in;
      end
   end

   assign init_busy = init_ff;

   // Crop store
   csc_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_head.addr),
      .rd_data (rd_data)
   );

   // Read stage: result info travels alongside the store read
   always_comb begin
      pv_in         = issue;
      pm_in.x       = q_head.out_x;
      pm_in.y       = q_head.out_y;
      pm_in.in_mask = q_head.in_mask;
      pm_in.hit     = q_head.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      pm_ff <= pm_in;
   end

   // Result queue
   assign opush     = pv_ff;
   assign rsp_empty = ocnt_ff == '0;
   assign opop      = rsp_pop && !rsp_empty;

   always_comb begin
      owr_in  = opush ? owr_ff + 1'b1 : owr_ff;
      ord_in  = opop ? ord_ff + 1'b1 : ord_ff;
      ocnt_in = ocnt_ff + (OPTR_W + 1)'(opush) - (OPTR_W + 1)'(opop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         ofifo_ff[owr_ff].x       <= pm_ff.x;
         ofifo_ff[owr_ff].y       <= pm_ff.y;
         ofifo_ff[owr_ff].in_mask <= pm_ff.in_mask;
         ofifo_ff[owr_ff].pixel   <= pm_ff.hit ? rd_data : '0;
      end
   end

   assign rsp_out_x       = ofifo_ff[ord_ff].x;
   assign rsp_out_y       = ofifo_ff[ord_ff].y;
   assign rsp_inside_mask = ofifo_ff[ord_ff].in_mask;
   assign rsp_pixel       = ofifo_ff[ord_ff].pixel;

endmodule

// ===== src/crop_scale_circle_mask_core.sv =====
// Top level of the crop, nearest-neighbor scale and circular mask core.
//
//   channel  dir  handshake      payload
//   req      in   push / full    command, src_x, src_y, src_color, disp_x, disp_y
//   rsp      out  pop / empty    out_x, out_y, inside_mask, pixel
//   csr      in   valid / ready  index (3 bits), data (11 bits)
//
// One request per cycle is accepted while full is low.
// The front end is a 6-stage pipe (multiplies and reciprocal divide by the display size),
// the back end one store access per cycle through a single write and a single read port, while
// no render waits for room in the result queue. After reset the store is swept to zero, with
// full held high. A clear request sweeps the store again; requests behind it wait in the queue.
// A stalled result queue backs up into the request queue, then holds the front pipe.
module crop_scale_circle_mask_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [1:0]                       req_command,
   input  logic [csc_pkg::SRC_W-1:0]        req_src_x,
   input  logic [csc_pkg::SRC_W-1:0]        req_src_y,
   input  logic [csc_pkg::COLOR_W-1:0]      req_src_color,
   input  logic [csc_pkg::DISP_W-1:0]       req_disp_x,
   input  logic [csc_pkg::DISP_W-1:0]       req_disp_y,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output logic [csc_pkg::DISP_W-1:0]       rsp_out_x,
   output logic [csc_pkg::DISP_W-1:0]       rsp_out_y,
   output logic                             rsp_inside_mask,
   output logic [csc_pkg::COLOR_W-1:0]      rsp_pixel,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [csc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csc_pkg::CFG_W-1:0]        csr_data
);
   import csc_pkg::*;

   csc_cfg_type cfg_in, cfg_ff;
   logic        front_stall, init_busy, accept;
   logic        q_push, q_full, q_pop, q_empty;
   csc_req_type q_data, q_head;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csc_csr_type'(csr_index))
            CSR_CROP_LEFT:   cfg_in.crop_left   = csr_data;
            CSR_CROP_TOP:    cfg_in.crop_top    = csr_data;
            CSR_CROP_WIDTH:  cfg_in.crop_width  = csr_data;
            CSR_CROP_HEIGHT: cfg_in.crop_height = csr_data;
            CSR_IMAGE_WIDTH: cfg_in.image_width = csr_data;
            CSR_DATA_RIGHT:  cfg_in.data_right  = csr_data[SRC_W-1:0];
            CSR_DATA_TOP:    cfg_in.data_top    = csr_data;
            CSR_MASK_RADIUS: cfg_in.mask_radius = csr_data[RAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crop_left   <= '0;
         cfg_ff.crop_top    <= '0;
         cfg_ff.crop_width  <= CFG_W'(480);
         cfg_ff.crop_height <= CFG_W'(480);
         cfg_ff.image_width <= CFG_W'(600);
         cfg_ff.data_right  <= SRC_W'(1023);
         cfg_ff.data_top    <= '1;
         cfg_ff.mask_radius <= RAD_W'(238);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request acceptance
   assign req_full = front_stall || init_busy;
   assign accept   = req_push && !req_full;

   csc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (accept),
      .in_command   (req_command),
      .in_src_x     (req_src_x),
      .in_src_y     (req_src_y),
      .in_src_color (req_src_color),
      .in_disp_x    (req_disp_x),
      .in_disp_y    (req_disp_y),
      .stall        (front_stall),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data)
   );

   csc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   csc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .init_busy       (init_busy),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_inside_mask (rsp_inside_mask),
      .rsp_pixel       (rsp_pixel)
   );

endmodule

// ===== src/csc_checker.sv =====
// Port-level assertions for the core, attached to the top level by bind.
module csc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_full,
   input logic                             rsp_pop,
   input logic                             rsp_empty,
   input logic [csc_pkg::DISP_W-1:0]       rsp_out_x,
   input logic [csc_pkg::DISP_W-1:0]       rsp_out_y,
   input logic                             rsp_inside_mask,
   input logic [csc_pkg::COLOR_W-1:0]      rsp_pixel
);

   // Reset empties the result queue and starts the store sweep
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_sweep: assert property (@(posedge clock) reset |=> req_full)
      else $error("request accepted during store sweep");

   // Pixels outside the circle are always black
   a_mask_black: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_inside_mask |-> rsp_pixel == '0)
      else $error("nonzero pixel outside mask");

   // A waiting result holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty &&
         $stable({rsp_out_x, rsp_out_y, rsp_inside_mask, rsp_pixel}))
      else $error("waiting result changed");

endmodule

bind crop_scale_circle_mask_core csc_checker u_csc_checker (.*);

// ===== tb/csc_result_checker.sv =====
// Scoreboard for the crop, scale and circle mask core: predicts every render result and compares.
`timescale 1ns / 1ps

module csc_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  logic [1:0]                    req_command,
   input  logic [csc_pkg::SRC_W-1:0]     req_src_x,
   input  logic [csc_pkg::SRC_W-1:0]     req_src_y,
   input  logic [csc_pkg::COLOR_W-1:0]   req_src_color,
   input  logic [csc_pkg::DISP_W-1:0]    req_disp_x,
   input  logic [csc_pkg::DISP_W-1:0]    req_disp_y,
   input  logic                          rsp_pop,
   input  logic                          rsp_empty,
   input  logic [csc_pkg::DISP_W-1:0]    rsp_out_x,
   input  logic [csc_pkg::DISP_W-1:0]    rsp_out_y,
   input  logic                          rsp_inside_mask,
   input  logic [csc_pkg::COLOR_W-1:0]   rsp_pixel,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [csc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [csc_pkg::CFG_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending,
   output int                            results_seen,
   output int                            inside_seen
);
   import csc_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [DISP_W-1:0]  out_x;
      logic [DISP_W-1:0]  out_y;
      logic               in_mask;
      logic [COLOR_W-1:0] pixel;
   } render_result_type;

   csc_cfg_type        cfg;
   logic [COLOR_W-1:0] pixel_store [STORE_DEPTH];
   render_result_type  expected_renders [$];
   int                 report_count;

   // Whole crop store back to black
   task automatic clear_store();
      for (int i = 0; i < STORE_DEPTH; i++) pixel_store[i] = '0;
   endtask

   // Register values and store contents after reset
   task automatic reset_model();
      cfg.crop_left   = '0;
      cfg.crop_top    = '0;
      cfg.crop_width  = CFG_W'(480);
      cfg.crop_height = CFG_W'(480);
      cfg.image_width = CFG_W'(600);
      cfg.data_right  = SRC_W'(1023);
      cfg.data_top    = CFG_W'(-1);
      cfg.mask_radius = RAD_W'(238);
      clear_store();
      expected_renders.delete();
   endtask

   task automatic write_register(input csc_csr_type idx, input logic [CFG_W-1:0] value);
      case (idx)
         CSR_CROP_LEFT:   cfg.crop_left   = value;
         CSR_CROP_TOP:    cfg.crop_top    = value;
         CSR_CROP_WIDTH:  cfg.crop_width  = value;
         CSR_CROP_HEIGHT: cfg.crop_height = value;
         CSR_IMAGE_WIDTH: cfg.image_width = value;
         CSR_DATA_RIGHT:  cfg.data_right  = value[SRC_W-1:0];
         CSR_DATA_TOP:    cfg.data_top    = value;
         CSR_MASK_RADIUS: cfg.mask_radius = value[RAD_W-1:0];
         default: ;
      endcase
   endtask

   // Source pixel into the crop store; black outside the data area
   task automatic store_load(input logic [SRC_W-1:0] sx, input logic [SRC_W-1:0] sy,
                             input logic [COLOR_W-1:0] color);
      int row;
      int col;
      int addr;
      bit have;
      row = int'(sy) - int'($signed(cfg.crop_top));
      col = int'(sx) - int'($signed(cfg.crop_left));
      if (row < 0 || row >= int'(cfg.crop_height)) return;
      if (col < 0 || col >= int'(cfg.crop_width)) return;
      have = int'(sx) < int'(cfg.image_width) && int'(sx) <= int'(cfg.data_right)
             && int'(sy) >= int'($signed(cfg.data_top));
      addr = row * int'(cfg.crop_width) + col;
      // addresses past the store depth are dropped
      if (addr < STORE_DEPTH) pixel_store[addr] = have ? color : '0;
   endtask

   // Nearest neighbor index, clamped to the last row or column
   function automatic int scale_index(input int d, input int size);
      int idx;
      idx = (d * size) / DISPLAY_SIZE;
      return (idx > size - 1) ? size - 1 : idx;
   endfunction

   function automatic render_result_type predict_render(input logic [DISP_W-1:0] dx,
                                                        input logic [DISP_W-1:0] dy);
      render_result_type res;
      int ddx;
      int ddy;
      int radius;
      int addr;
      ddx = int'(dx) - HALF;
      ddy = int'(dy) - HALF;
      radius = int'(cfg.mask_radius);
      res.out_x = dx;
      res.out_y = dy;
      res.in_mask = (ddx * ddx + ddy * ddy <= radius * radius);
      res.pixel = '0;
      // empty crop reads black, mask flag still computed
      if (res.in_mask && cfg.crop_width != 0 && cfg.crop_height != 0) begin
         addr = scale_index(int'(dy), int'(cfg.crop_height)) * int'(cfg.crop_width)
                + scale_index(int'(dx), int'(cfg.crop_width));
         if (addr < STORE_DEPTH) res.pixel = pixel_store[addr];
      end
      return res;
   endfunction

   task automatic check_result();
      render_result_type want;
      if (expected_renders.size() == 0) begin
         fail_count++;
         if (report_count < MAX_REPORTS)
            $display("unexpected result: x %0d y %0d mask %0b pixel %h",
                     rsp_out_x, rsp_out_y, rsp_inside_mask, rsp_pixel);
         report_count++;
         return;
      end
      want = expected_renders.pop_front();
      if (want.in_mask) inside_seen++;
      if (rsp_out_x !== want.out_x || rsp_out_y !== want.out_y ||
          rsp_inside_mask !== want.in_mask || rsp_pixel !== want.pixel) begin
         fail_count++;
         if (report_count < MAX_REPORTS)
            $display("mismatch: expected x %0d y %0d mask %0b pixel %h,",
                     want.out_x, want.out_y, want.in_mask, want.pixel,
                     " got x %0d y %0d mask %0b pixel %h",
                     rsp_out_x, rsp_out_y, rsp_inside_mask, rsp_pixel);
         report_count++;
      end
   endtask

   // Watch all three channels at each clock edge
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_valid && csr_ready) write_register(csc_csr_type'(csr_index), csr_data);
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            check_result();
         end
         if (req_push && !req_full) begin
            case (req_command)
               CMD_LOAD:   store_load(req_src_x, req_src_y, req_src_color);
               CMD_RENDER: expected_renders.push_back(predict_render(req_disp_x, req_disp_y));
               CMD_CLEAR:  clear_store();
               default: ;  // unused command is ignored
            endcase
         end
      end
      pending = expected_renders.size();
   end

endmodule

// ===== tb/crop_scale_circle_mask_core_test.sv =====
// Testbench top for the crop, scale and circle mask core: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module crop_scale_circle_mask_core_test;
   import csc_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT  = 4000000;
   localparam int         DRAIN_CYCLES = 24;
   localparam int         NUM_PHASES   = 12;
   localparam int         PHASE_ITEMS  = 75;
   localparam int         CLEAR_PHASE  = 6;
   localparam int         HOLD_PHASE   = 4;
   localparam int         HOLD_CYCLES  = 600;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [1:0]           req_command;
   logic [SRC_W-1:0]     req_src_x;
   logic [SRC_W-1:0]     req_src_y;
   logic [COLOR_W-1:0]   req_src_color;
   logic [DISP_W-1:0]    req_disp_x;
   logic [DISP_W-1:0]    req_disp_y;
   logic                 rsp_pop;
   logic                 rsp_empty;
   logic [DISP_W-1:0]    rsp_out_x;
   logic [DISP_W-1:0]    rsp_out_y;
   logic                 rsp_inside_mask;
   logic [COLOR_W-1:0]   rsp_pixel;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   int fail_count;
   int pending;
   int results_seen;
   int inside_seen;
   int load_count;
   int render_count;
   int clear_count;
   int ignored_count;
   int csr_write_count;
   int setting_count;
   int cycle_count;
   bit req_burst;
   bit rsp_burst;
   bit hold_request;

   crop_scale_circle_mask_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_src_x       (req_src_x),
      .req_src_y       (req_src_y),
      .req_src_color   (req_src_color),
      .req_disp_x      (req_disp_x),
      .req_disp_y      (req_disp_y),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_inside_mask (rsp_inside_mask),
      .rsp_pixel       (rsp_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   csc_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_src_x       (req_src_x),
      .req_src_y       (req_src_y),
      .req_src_color   (req_src_color),
      .req_disp_x      (req_disp_x),
      .req_disp_y      (req_disp_y),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_inside_mask (rsp_inside_mask),
      .rsp_pixel       (rsp_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_seen    (results_seen),
      .inside_seen     (inside_seen)
   );

   // Clock, 12 ns period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("status: fail");
      $finish;
   end

   // One request: random gap, then hold push until it is taken
   task automatic send_request(input logic [1:0] cmd, input logic [SRC_W-1:0] sx,
                               input logic [SRC_W-1:0] sy, input logic [COLOR_W-1:0] color,
                               input logic [DISP_W-1:0] dx, input logic [DISP_W-1:0] dy);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_command   <= cmd;
      req_src_x     <= sx;
      req_src_y     <= sy;
      req_src_color <= color;
      req_disp_x    <= dx;
      req_disp_y    <= dy;
      do @(posedge clock); while (req_full);
      case (cmd)
         CMD_LOAD:   load_count++;
         CMD_RENDER: render_count++;
         CMD_CLEAR:  clear_count++;
         default:    ignored_count++;
      endcase
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
   endtask

   task automatic send_load(input int sx, input int sy, input int color);
      send_request(CMD_LOAD, SRC_W'(sx), SRC_W'(sy), COLOR_W'(color),
                   DISP_W'($urandom), DISP_W'($urandom));
   endtask

   task automatic send_render(input int dx, input int dy);
      send_request(CMD_RENDER, SRC_W'($urandom), SRC_W'($urandom), COLOR_W'($urandom),
                   DISP_W'(dx), DISP_W'(dy));
   endtask

   // Close a phase with a render, then wait until the block is quiet
   task automatic drain_block();
      send_render($urandom_range(0, 479), $urandom_range(0, 479));
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csc_csr_type idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_write_count++;
   endtask

   // All eight registers; unused upper bits of the narrow ones get random values
   task automatic write_setting(input csc_cfg_type s);
      write_csr(CSR_CROP_LEFT,   s.crop_left);
      write_csr(CSR_CROP_TOP,    s.crop_top);
      write_csr(CSR_CROP_WIDTH,  s.crop_width);
      write_csr(CSR_CROP_HEIGHT, s.crop_height);
      write_csr(CSR_IMAGE_WIDTH, s.image_width);
      write_csr(CSR_DATA_RIGHT,  {1'($urandom), s.data_right});
      write_csr(CSR_DATA_TOP,    s.data_top);
      write_csr(CSR_MASK_RADIUS, {2'($urandom), s.mask_radius});
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   function automatic csc_cfg_type make_setting(input int left, input int top, input int w,
                                                input int h, input int iw, input int dr,
                                                input int dt, input int radius);
      csc_cfg_type s;
      s.crop_left   = CFG_W'(left);
      s.crop_top    = CFG_W'(top);
      s.crop_width  = CFG_W'(w);
      s.crop_height = CFG_W'(h);
      s.image_width = CFG_W'(iw);
      s.data_right  = SRC_W'(dr);
      s.data_top    = CFG_W'(dt);
      s.mask_radius = RAD_W'(radius);
      return s;
   endfunction

   // Mostly small crops so loads cover the store densely
   function automatic csc_cfg_type random_setting();
      csc_cfg_type s;
      s.crop_width  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 1024))
                                                  : CFG_W'($urandom_range(1, 48));
      s.crop_height = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 1024))
                                                  : CFG_W'($urandom_range(1, 48));
      if ($urandom_range(0, 15) == 0) s.crop_width = '0;
      if ($urandom_range(0, 15) == 0) s.crop_height = '0;
      s.crop_left   = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2047))
                                                  : CFG_W'($urandom_range(0, 1040) - 40);
      s.crop_top    = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 2047))
                                                  : CFG_W'($urandom_range(0, 1040) - 40);
      s.image_width = $urandom_range(0, 1) ? CFG_W'(1024) : CFG_W'($urandom_range(1, 1024));
      s.data_right  = $urandom_range(0, 1) ? SRC_W'(1023) : SRC_W'($urandom_range(0, 1023));
      s.data_top    = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 264) - 64)
                                           : CFG_W'($urandom_range(0, 2047));
      s.mask_radius = $urandom_range(0, 3) ? RAD_W'($urandom_range(150, 511))
                                           : RAD_W'($urandom_range(0, 511));
      return s;
   endfunction

   // Mostly loads aimed into the window and renders, plus noise
   task automatic send_random_request(input csc_cfg_type s);
      int pick;
      int sx;
      int sy;
      pick = $urandom_range(0, 99);
      if (pick < 45 && s.crop_width != 0 && s.crop_height != 0) begin
         sx = int'($signed(s.crop_left)) + $urandom_range(0, int'(s.crop_width) - 1);
         sy = int'($signed(s.crop_top)) + $urandom_range(0, int'(s.crop_height) - 1);
         if (sx < 0 || sx > 1023) sx = $urandom_range(0, 1023);
         if (sy < 0 || sy > 1023) sy = $urandom_range(0, 1023);
         send_load(sx, sy, $urandom);
      end else if (pick < 85) begin
         if ($urandom_range(0, 9) == 0)
            send_render($urandom_range(480, 511), $urandom_range(0, 511));
         else
            send_render($urandom_range(0, 479), $urandom_range(0, 479));
      end else if (pick < 95) begin
         send_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      end else if (pick < 98) begin
         send_request(CMD_UNUSED, SRC_W'($urandom), SRC_W'($urandom), COLOR_W'($urandom),
                      DISP_W'($urandom), DISP_W'($urandom));
      end else begin
         send_render($urandom_range(0, 511), $urandom_range(0, 511));
      end
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_burst = 1'b0;
      rsp_pop <= 1'b0;
      wait (reset == 1'b1);
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      end
   end

   // Request side and verdict
   initial begin
      csc_cfg_type s;
      req_burst = 1'b0;
      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_command   <= CMD_LOAD;
      req_src_x     <= '0;
      req_src_y     <= '0;
      req_src_color <= '0;
      req_disp_x    <= '0;
      req_disp_y    <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_CROP_LEFT;
      csr_data      <= '0;
      hold_request  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: edge of the mask, window limits, clear
      send_load(0, 0, 16'hFFFF);
      send_load(2, 240, 16'hA5A5);
      send_load(479, 479, 16'h5A5A);
      send_load(480, 0, 16'h1111);       // past crop width
      send_load(1023, 1023, 16'hFFFF);   // outside window
      send_render(2, 240);               // exactly on the circle
      send_render(240, 240);
      send_render(0, 0);
      send_render(1, 240);               // just outside the circle
      send_request(CMD_UNUSED, SRC_W'($urandom), SRC_W'($urandom), COLOR_W'($urandom),
                   DISP_W'($urandom), DISP_W'($urandom));
      send_request(CMD_CLEAR, '0, '0, '0, '0, '0);
      send_render(2, 240);               // cleared, reads black
      drain_block();

      // Empty crop
      write_setting(make_setting(-5, -3, 0, 0, 600, 1023, -1, 511));
      send_load(0, 0, 16'hFFFF);
      send_render(511, 511);
      send_render(0, 479);
      drain_block();

      // Full size crop, addresses past the store depth
      write_setting(make_setting(0, 0, 1024, 1024, 1024, 1023, -1024, 511));
      send_load(1023, 1023, 16'hBEEF);
      send_render(511, 511);
      send_load(6, 4, 16'h8001);
      send_render(3, 2);
      drain_block();

      // Data edge, data top and image width stored as black
      write_setting(make_setting(0, 0, 16, 16, 1, 0, 8, 511));
      send_load(0, 8, 16'h0F0F);
      send_load(1, 8, 16'hF0F0);
      send_load(0, 7, 16'h3333);
      send_render(0, 240);
      send_render(30, 240);
      send_render(0, 225);
      drain_block();

      // Random phases, the first two at the register extremes
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == 0)
            s = make_setting(-1024, -1024, 1, 1, 1, 0, -1024, 0);
         else if (phase == 1)
            s = make_setting(1023, 1023, 1024, 1024, 1024, 1023, 1023, 511);
         else
            s = random_setting();
         write_setting(s);
         if (phase == CLEAR_PHASE) send_request(CMD_CLEAR, '0, '0, '0, '0, '0);
         if (phase == HOLD_PHASE) begin
            req_burst = 1'b1;
            hold_request <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_request(s);
         drain_block();
      end

      // Wait out the tail, then the verdict
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("run: %0d loads, %0d renders, %0d clears, %0d ignored, %0d settings (%0d writes)",
               load_count, render_count, clear_count, ignored_count, setting_count,
               csr_write_count);
      $display("run: %0d results checked, %0d inside the mask, %0d failures",
               results_seen, inside_seen, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
